// ===== rtl/core/mwe_pkg.sv =====
// Shared types, constants and helpers for the Microwire EEPROM master.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mwe_pkg;

   // Geometry of the serial memory
   localparam int ADDRESS_BITS = 8;
   localparam int WORD_BITS    = 16;
   localparam int MAX_BURST    = 256;
   localparam int CMD_BITS     = 4 + ADDRESS_BITS;

   localparam int TICK_W      = 24;
   localparam int COUNT_W     = 9;
   localparam int BIT_W       = 5;
   localparam int CMD_IDX_W   = $clog2(CMD_BITS);
   localparam int WORD_IDX_W  = $clog2(WORD_BITS);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 24;

   localparam logic [BIT_W-1:0]   CMD_LEN   = BIT_W'(CMD_BITS);
   localparam logic [BIT_W-1:0]   WORD_LEN  = BIT_W'(WORD_BITS);
   localparam logic [BIT_W-1:0]   WORD_LAST = BIT_W'(WORD_BITS - 1);
   localparam logic [COUNT_W-1:0] BURST_MAX = COUNT_W'(MAX_BURST);

   // Opcodes
   localparam logic [1:0] OP_READ  = 2'b10;
   localparam logic [1:0] OP_WRITE = 2'b01;
   localparam logic [1:0] OP_MISC  = 2'b00;

   // Address fields of the miscellaneous commands
   localparam logic [ADDRESS_BITS-1:0] ADDR_ENABLE  = {ADDRESS_BITS{1'b1}};
   localparam logic [ADDRESS_BITS-1:0] ADDR_DISABLE =
      ADDRESS_BITS'((1 << (ADDRESS_BITS - 2)) - 1);
   localparam logic [ADDRESS_BITS-1:0] ADDR_WRALL   =
      ADDRESS_BITS'((1 << (ADDRESS_BITS - 1)) - 2);

   // Item modes
   localparam logic [2:0] MODE_TICK      = 3'd0;
   localparam logic [2:0] MODE_READ      = 3'd1;
   localparam logic [2:0] MODE_WRITE     = 3'd2;
   localparam logic [2:0] MODE_ENABLE    = 3'd3;
   localparam logic [2:0] MODE_DISABLE   = 3'd4;
   localparam logic [2:0] MODE_WRITE_ALL = 3'd5;

   // Status codes
   localparam logic [1:0] STATUS_IDLE = 2'd0;
   localparam logic [1:0] STATUS_DONE = 2'd1;
   localparam logic [1:0] STATUS_BUSY = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETUP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POLL   = 2'd3;

   // Register reset values
   localparam logic [15:0]       RST_PHASE  = 16'd4;
   localparam logic [15:0]       RST_SETUP  = 16'd4;
   localparam logic [15:0]       RST_SETTLE = 16'd8;
   localparam logic [TICK_W-1:0] RST_POLL   = 24'd100000;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_LEAD   = 11'b000_0000_0010,
      S_SETUP  = 11'b000_0000_0100,
      S_CMD    = 11'b000_0000_1000,
      S_DUMMY  = 11'b000_0001_0000,
      S_DIN    = 11'b000_0010_0000,
      S_DOUT   = 11'b000_0100_0000,
      S_TAIL   = 11'b000_1000_0000,
      S_SETTLE = 11'b001_0000_0000,
      S_POLL   = 11'b010_0000_0000,
      S_DONE   = 11'b100_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      K_SWITCH = 2'd0,
      K_READ   = 2'd1,
      K_WRITE  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [15:0]       phase_ticks;
      logic [15:0]       setup_ticks;
      logic [15:0]       settle_ticks;
      logic [TICK_W-1:0] poll_limit;
   } cfg_type;

   typedef struct packed {
      logic                 chip_select;
      logic                 serial_clock;
      logic                 data_in_pin;
      logic [WORD_BITS-1:0] read_word;
      logic                 read_valid;
      logic                 read_last;
      logic [1:0]           status;
   } result_type;

   // Header 0 then start bit 1, opcode, address
   function automatic logic [CMD_BITS-1:0] make_cmd(input logic [1:0] op,
                                                    input logic [ADDRESS_BITS-1:0] addr);
      return {2'b01, op, addr};
   endfunction

endpackage

// ===== rtl/core/mwe_csr.sv =====
// Configuration register bank of the Microwire EEPROM master.
// Depends on mwe_pkg for the register indexes, reset values and cfg_type.
`timescale 1ns / 1ps

module mwe_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mwe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mwe_pkg::CSR_DATA_W-1:0]   csr_data,
   output mwe_pkg::cfg_type                 cfg
);
   import mwe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always accepted and take effect on the next cycle
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the index and replace one field
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PHASE:  cfg_in.phase_ticks  = csr_data[15:0];
            CSR_SETUP:  cfg_in.setup_ticks  = csr_data[15:0];
            CSR_SETTLE: cfg_in.settle_ticks = csr_data[15:0];
            CSR_POLL:   cfg_in.poll_limit   = csr_data[TICK_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_ticks  <= RST_PHASE;
         cfg_ff.setup_ticks  <= RST_SETUP;
         cfg_ff.settle_ticks <= RST_SETTLE;
         cfg_ff.poll_limit   <= RST_POLL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/mwe_seq.sv =====
// Frame sequencer: state registers plus the one-item step and pin decode.
// Depends on mwe_pkg for states, codes, cfg_type and result_type.
`timescale 1ns / 1ps

module mwe_seq (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_en,
   input  logic [2:0]                         item_mode,
   input  logic [mwe_pkg::ADDRESS_BITS-1:0]   item_address,
   input  logic [mwe_pkg::WORD_BITS-1:0]      item_write_data,
   input  logic [mwe_pkg::COUNT_W-1:0]        item_word_count,
   input  logic                               item_block,
   input  logic                               item_pin,
   input  mwe_pkg::cfg_type                   cfg,
   output mwe_pkg::result_type                res
);
   import mwe_pkg::*;

   state_type              state_ff, state_in;
   kind_type               kind_ff, kind_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [1:0]             phase_ff, phase_in;
   logic [BIT_W-1:0]       bit_ff, bit_in;
   logic [CMD_BITS-1:0]    cmd_ff, cmd_in;
   logic [WORD_BITS-1:0]   shift_ff, shift_in;
   logic [COUNT_W-1:0]     words_ff, words_in;
   logic [2:0]             pend_ff, pend_in;
   logic                   block_ff, block_in;
   logic [WORD_BITS-1:0]   last_word_ff, last_word_in;

   logic                   busy;
   logic                   timed;
   logic [15:0]            dur;
   logic [15:0]            unit;
   logic [TICK_W-1:0]      limit;
   logic [TICK_W:0]        cnt_inc;
   logic [1:0]             ph_step;
   logic [BIT_W-1:0]       bc_step;
   logic [COUNT_W-1:0]     words_dec;
   logic [COUNT_W-1:0]     burst;
   logic                   load_go;
   logic [CMD_BITS-1:0]    load_cmd;
   kind_type               load_kind;
   logic                   word_done;
   logic                   word_last;
   logic [CMD_IDX_W-1:0]   cmd_idx;
   logic [WORD_IDX_W-1:0]  word_idx;

   assign busy      = !(state_ff == S_IDLE || state_ff == S_DONE);
   assign unit      = (cfg.phase_ticks == '0) ? 16'd1 : cfg.phase_ticks;
   assign limit     = (cfg.poll_limit == '0) ? TICK_W'(1) : cfg.poll_limit;
   assign cnt_inc   = {1'b0, tick_ff} + (TICK_W + 1)'(1);
   assign ph_step   = phase_ff + 2'd1;
   assign bc_step   = bit_ff + BIT_W'(1);
   assign words_dec = (words_ff != '0) ? words_ff - COUNT_W'(1) : words_ff;

   // Clamp the burst length
   always_comb begin
      if (item_word_count == '0) begin
         burst = COUNT_W'(1);
      end else if (item_word_count > BURST_MAX) begin
         burst = BURST_MAX;
      end else begin
         burst = item_word_count;
      end
   end

   // Length of the current timed state
   always_comb begin
      timed = 1'b1;
      dur   = unit;
      unique case (state_ff)
         S_LEAD, S_CMD, S_DUMMY, S_DIN, S_DOUT, S_TAIL: dur = unit;
         S_SETUP:  dur = cfg.setup_ticks;
         S_SETTLE: dur = cfg.settle_ticks;
         default:  timed = 1'b0;
      endcase
   end

   // Step the sequence by one item
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      tick_in      = tick_ff;
      phase_in     = phase_ff;
      bit_in       = bit_ff;
      cmd_in       = cmd_ff;
      shift_in     = shift_ff;
      words_in     = words_ff;
      pend_in      = pend_ff;
      block_in     = block_ff;
      last_word_in = last_word_ff;
      load_go      = 1'b0;
      load_cmd     = cmd_ff;
      load_kind    = kind_ff;
      word_done    = 1'b0;
      word_last    = 1'b0;

      if (item_en && item_mode == MODE_TICK) begin
         if (state_ff == S_POLL) begin
            // Poll ready until the data-out pin reads low or the limit runs out
            if (!item_pin || cnt_inc >= (TICK_W + 1)'(limit)) begin
               tick_in = '0;
               if (pend_ff == MODE_WRITE_ALL) begin
                  load_go   = 1'b1;
                  load_cmd  = make_cmd(OP_MISC, ADDR_DISABLE);
                  load_kind = K_SWITCH;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               tick_in = cnt_inc[TICK_W-1:0];
            end
         end else if (timed) begin
            if (cnt_inc >= (TICK_W + 1)'(dur)) begin
               tick_in = '0;
               unique case (state_ff)
                  S_LEAD: begin
                     state_in = S_SETUP;
                     if (cfg.setup_ticks == '0) begin
                        state_in = S_CMD;
                        phase_in = '0;
                        bit_in   = '0;
                     end
                  end
                  S_SETUP: begin
                     state_in = S_CMD;
                     phase_in = '0;
                     bit_in   = '0;
                  end
                  S_SETTLE: state_in = S_POLL;
                  S_TAIL: begin
                     if (kind_ff == K_WRITE) begin
                        state_in = (cfg.settle_ticks == '0) ? S_POLL : S_SETTLE;
                     end else if (pend_ff == MODE_WRITE_ALL &&
                                  cmd_ff == make_cmd(OP_MISC, ADDR_ENABLE)) begin
                        load_go   = 1'b1;
                        load_cmd  = make_cmd(OP_MISC, ADDR_WRALL | ADDRESS_BITS'(block_ff));
                        load_kind = K_WRITE;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                     // Shifting states: advance a quarter bit
                     phase_in = ph_step;
                     if (phase_ff == 2'd3) begin
                        priority if (state_ff == S_CMD && bc_step >= CMD_LEN) begin
                           bit_in = '0;
                           unique case (kind_ff)
                              K_READ:  state_in = S_DUMMY;
                              K_WRITE: state_in = S_DOUT;
                              default: state_in = S_TAIL;
                           endcase
                        end else if (state_ff == S_DUMMY) begin
                           bit_in   = '0;
                           state_in = S_DIN;
                        end else if (state_ff == S_DOUT && bc_step >= WORD_LEN) begin
                           bit_in   = bc_step;
                           state_in = S_TAIL;
                        end else if (state_ff == S_DIN && bc_step >= WORD_LEN) begin
                           bit_in   = '0;
                           words_in = words_dec;
                           if (words_dec == '0) begin
                              state_in = S_TAIL;
                           end
                        end else begin
                           bit_in = bc_step;
                        end
                        // Sample the inverted data-out pin on entry to phase 0
                        if (state_in == S_DIN) begin
                           shift_in = {shift_ff[WORD_BITS-2:0], ~item_pin};
                           if (bit_in == WORD_LAST) begin
                              last_word_in = shift_in;
                              word_done    = 1'b1;
                              word_last    = (words_in <= COUNT_W'(1));
                           end
                        end
                     end
                  end
               endcase
            end else begin
               tick_in = cnt_inc[TICK_W-1:0];
            end
         end
      end else if (item_en && item_mode <= MODE_WRITE_ALL && !busy) begin
         // Start a new frame
         pend_in  = item_mode;
         shift_in = '0;
         block_in = item_block;
         load_go  = 1'b1;
         unique case (item_mode)
            MODE_READ: begin
               words_in  = burst;
               load_cmd  = make_cmd(OP_READ, item_address);
               load_kind = K_READ;
            end
            MODE_WRITE: begin
               shift_in  = item_write_data;
               load_cmd  = make_cmd(OP_WRITE, item_address);
               load_kind = K_WRITE;
            end
            MODE_ENABLE: begin
               load_cmd  = make_cmd(OP_MISC, ADDR_ENABLE);
               load_kind = K_SWITCH;
            end
            MODE_DISABLE: begin
               load_cmd  = make_cmd(OP_MISC, ADDR_DISABLE);
               load_kind = K_SWITCH;
            end
            default: begin
               shift_in  = item_write_data;
               load_cmd  = make_cmd(OP_MISC, ADDR_ENABLE);
               load_kind = K_SWITCH;
            end
         endcase
      end

      // Load a frame and restart its timing
      if (load_go) begin
         cmd_in   = load_cmd;
         kind_in  = load_kind;
         state_in = S_LEAD;
         tick_in  = '0;
         phase_in = '0;
         bit_in   = '0;
      end
   end

   assign cmd_idx  = CMD_IDX_W'(CMD_BITS - 1) - bit_in[CMD_IDX_W-1:0];
   assign word_idx = WORD_IDX_W'(WORD_BITS - 1) - bit_in[WORD_IDX_W-1:0];

   // Decode pins and status from the new state
   always_comb begin
      res.chip_select  = 1'b0;
      res.serial_clock = 1'b1;
      res.data_in_pin  = 1'b1;
      res.read_word    = last_word_in;
      res.read_valid   = word_done;
      res.read_last    = word_last;
      res.status       = STATUS_BUSY;
      unique case (state_in)
         S_IDLE: res.status = STATUS_IDLE;
         S_DONE: res.status = STATUS_DONE;
         S_LEAD: res.data_in_pin = 1'b0;
         S_SETUP: begin
            res.serial_clock = 1'b0;
            res.data_in_pin  = 1'b0;
         end
         S_CMD: begin
            res.chip_select  = 1'b1;
            res.serial_clock = phase_in[1];
            res.data_in_pin  = cmd_in[cmd_idx];
         end
         S_DOUT: begin
            res.chip_select  = 1'b1;
            res.serial_clock = phase_in[1];
            res.data_in_pin  = shift_in[word_idx];
         end
         S_DUMMY, S_DIN: begin
            res.chip_select  = 1'b1;
            res.serial_clock = phase_in[1];
            res.data_in_pin  = 1'b0;
         end
         S_TAIL: begin
            res.chip_select  = 1'b1;
            res.serial_clock = 1'b0;
            res.data_in_pin  = 1'b0;
         end
         S_SETTLE: res.data_in_pin = 1'b0;
         S_POLL: begin
            res.chip_select = 1'b1;
            res.data_in_pin = 1'b0;
         end
         default: res.status = STATUS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= K_SWITCH;
         tick_ff      <= '0;
         phase_ff     <= '0;
         bit_ff       <= '0;
         cmd_ff       <= '0;
         shift_ff     <= '0;
         words_ff     <= '0;
         pend_ff      <= '0;
         block_ff     <= 1'b0;
         last_word_ff <= '0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         tick_ff      <= tick_in;
         phase_ff     <= phase_in;
         bit_ff       <= bit_in;
         cmd_ff       <= cmd_in;
         shift_ff     <= shift_in;
         words_ff     <= words_in;
         pend_ff      <= pend_in;
         block_ff     <= block_in;
         last_word_ff <= last_word_in;
      end
   end

   // Bit position stays inside the field being shifted
   a_cmd_bits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMD) |-> (bit_ff < CMD_LEN))
      else $error("command bit index out of range");

   a_data_bits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIN || state_ff == S_DOUT) |-> (bit_ff < WORD_LEN))
      else $error("data bit index out of range");

   // A read run never sits in sampling with no words left
   a_words_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIN) |-> (words_ff != '0))
      else $error("sampling with empty word count");

   // Ticks leave an idle block idle
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      (item_en && item_mode == MODE_TICK && state_ff == S_IDLE) |=> (state_ff == S_IDLE))
      else $error("tick moved an idle sequencer");

endmodule

// ===== rtl/core/microwire_eeprom_master.sv =====
// Top level of the Microwire EEPROM master: input register, sequencer, result register.
// Depends on mwe_pkg, mwe_csr and mwe_seq.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | mode, address, write_data, word_count,
//           |           |                       | block_select, data_out_pin
//   rsp     | out       | rsp_valid / rsp_ready | chip_select, serial_clock, data_in_pin,
//           |           |                       | read_word, read_valid, read_last, status
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// One item per clock sustained while rsp_ready stays high; each accepted item passes through
// the input register, then the sequencer step into the result register.
// Reset loads the register defaults, sends the sequencer idle and empties both registers.
// With rsp_ready low the result holds; req_ready stays high only while the input register
// is empty, so at most one more beat is taken. Register writes take effect on the next
// cycle; csr_ready stays high.
`timescale 1ns / 1ps

module microwire_eeprom_master (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_mode,
   input  logic [mwe_pkg::ADDRESS_BITS-1:0]   req_address,
   input  logic [mwe_pkg::WORD_BITS-1:0]      req_write_data,
   input  logic [mwe_pkg::COUNT_W-1:0]        req_word_count,
   input  logic                               req_block_select,
   input  logic                               req_data_out_pin,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_chip_select,
   output logic                               rsp_serial_clock,
   output logic                               rsp_data_in_pin,
   output logic [mwe_pkg::WORD_BITS-1:0]      rsp_read_word,
   output logic                               rsp_read_valid,
   output logic                               rsp_read_last,
   output logic [1:0]                         rsp_status,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mwe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mwe_pkg::CSR_DATA_W-1:0]     csr_data
);
   import mwe_pkg::*;

   logic                     in_valid_ff, in_valid_in;
   logic [2:0]               in_mode_ff;
   logic [ADDRESS_BITS-1:0]  in_address_ff;
   logic [WORD_BITS-1:0]     in_wdata_ff;
   logic [COUNT_W-1:0]       in_count_ff;
   logic                     in_block_ff;
   logic                     in_pin_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   result_type               rsp_ff;
   result_type               step_res;
   cfg_type                  cfg;
   logic                     adv;
   logic                     req_take;

   // Move the held beat through the sequencer when the result slot frees
   assign adv       = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || adv;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take ? 1'b1 : (adv ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   mwe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mwe_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .item_en         (adv),
      .item_mode       (in_mode_ff),
      .item_address    (in_address_ff),
      .item_write_data (in_wdata_ff),
      .item_word_count (in_count_ff),
      .item_block      (in_block_ff),
      .item_pin        (in_pin_ff),
      .cfg             (cfg),
      .res             (step_res)
   );

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the incoming beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff    <= req_mode;
         in_address_ff <= req_address;
         in_wdata_ff   <= req_write_data;
         in_count_ff   <= req_word_count;
         in_block_ff   <= req_block_select;
         in_pin_ff     <= req_data_out_pin;
      end
   end

   // Capture the result beat
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chip_select  = rsp_ff.chip_select;
   assign rsp_serial_clock = rsp_ff.serial_clock;
   assign rsp_data_in_pin  = rsp_ff.data_in_pin;
   assign rsp_read_word    = rsp_ff.read_word;
   assign rsp_read_valid   = rsp_ff.read_valid;
   assign rsp_read_last    = rsp_ff.read_last;
   assign rsp_status       = rsp_ff.status;

endmodule

// ===== bench/tb_microwire_eeprom_master.sv =====
// Testbench for microwire_eeprom_master: drives command and tick items, predicts pin levels.
// Depends on mwe_pkg and the RTL top level; a tracker class holds the expected pin trace.
`timescale 1ns / 1ps

module tb_microwire_eeprom_master;
   import mwe_pkg::*;

   localparam int CYCLE_LIMIT   = 4_000_000;

   // Pin levels the block should show for each item, built from the serial frame sequence
   class frame_tracker;
      int unsigned phase_ticks, setup_ticks, settle_ticks, poll_limit;
      state_type seq;
      kind_type kind;
      int unsigned tick_count, phase, bit_index, words_left;
      logic [CMD_BITS-1:0] cmd_shift;
      logic [WORD_BITS-1:0] data_shift, last_word;
      logic [2:0] pending;
      logic block_bit;
      bit word_done, word_final;
      result_type pending_pins[$];
      int mismatches, beats;

      function new();
         phase_ticks  = RST_PHASE;
         setup_ticks  = RST_SETUP;
         settle_ticks = RST_SETTLE;
         poll_limit   = RST_POLL;
         seq = S_IDLE;
         kind = K_SWITCH;
         tick_count = 0;
         phase = 0;
         bit_index = 0;
         words_left = 0;
         cmd_shift = '0;
         data_shift = '0;
         last_word = '0;
         pending = '0;
         block_bit = 1'b0;
         mismatches = 0;
         beats = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_PHASE:  phase_ticks  = value[15:0];
            CSR_SETUP:  setup_ticks  = value[15:0];
            CSR_SETTLE: settle_ticks = value[15:0];
            default:    poll_limit   = value;
         endcase
      endfunction

      function bit in_frame();
         return !(seq == S_IDLE || seq == S_DONE);
      endfunction

      // Header 0, start bit 1, opcode, address
      function logic [CMD_BITS-1:0] frame_cmd(logic [1:0] op, logic [ADDRESS_BITS-1:0] addr);
         return (CMD_BITS'(1) << (ADDRESS_BITS + 2)) | (CMD_BITS'(op) << ADDRESS_BITS)
                | CMD_BITS'(addr);
      endfunction

      function void load_frame(logic [CMD_BITS-1:0] cmd, kind_type k);
         cmd_shift = cmd;
         kind = k;
         seq = S_LEAD;
         tick_count = 0;
         phase = 0;
         bit_index = 0;
      endfunction

      function int unsigned unit_ticks();
         return (phase_ticks != 0) ? phase_ticks : 1;
      endfunction

      // Length of the current timed state; 0 back for states that wait on something else
      function bit timed_state(output int unsigned d);
         d = 0;
         case (seq)
            S_LEAD, S_CMD, S_DUMMY, S_DIN, S_DOUT, S_TAIL: begin
               d = unit_ticks();
               return 1'b1;
            end
            S_SETUP: begin
               d = setup_ticks;
               return 1'b1;
            end
            S_SETTLE: begin
               d = settle_ticks;
               return 1'b1;
            end
            default: return 1'b0;
         endcase
      endfunction

      // Shift in the inverted data-out level; flag a word on its last bit
      function void sample_bit(logic pin);
         data_shift = {data_shift[WORD_BITS-2:0], ~pin};
         if (bit_index == WORD_BITS - 1) begin
            last_word = data_shift;
            word_done = 1'b1;
            word_final = (words_left <= 1);
         end
      endfunction

      function void after_tail();
         if (kind == K_WRITE) begin
            seq = S_SETTLE;
         end else if (pending == MODE_WRITE_ALL && cmd_shift == frame_cmd(OP_MISC, ADDR_ENABLE))
         begin
            load_frame(frame_cmd(OP_MISC, ADDR_WRALL | block_bit), K_WRITE);
         end else begin
            seq = S_DONE;
         end
      endfunction

      function void advance(logic pin);
         case (seq)
            S_LEAD: begin
               seq = S_SETUP;
               return;
            end
            S_SETUP: begin
               seq = S_CMD;
               phase = 0;
               bit_index = 0;
               return;
            end
            S_TAIL: begin
               after_tail();
               return;
            end
            S_SETTLE: begin
               seq = S_POLL;
               return;
            end
            default: ;
         endcase
         phase = (phase + 1) & 3;
         if (phase == 0) begin
            bit_index++;
            if (seq == S_CMD && bit_index >= CMD_BITS) begin
               bit_index = 0;
               if (kind == K_READ) seq = S_DUMMY;
               else if (kind == K_WRITE) seq = S_DOUT;
               else seq = S_TAIL;
            end else if (seq == S_DUMMY) begin
               bit_index = 0;
               seq = S_DIN;
            end else if (seq == S_DOUT && bit_index >= WORD_BITS) begin
               seq = S_TAIL;
            end else if (seq == S_DIN && bit_index >= WORD_BITS) begin
               bit_index = 0;
               if (words_left > 0) words_left--;
               if (words_left == 0) seq = S_TAIL;
            end
            if (seq == S_DIN) sample_bit(pin);
         end
      endfunction

      function void tick(logic pin);
         int unsigned d, lim;
         if (seq == S_POLL) begin
            lim = (poll_limit != 0) ? poll_limit : 1;
            tick_count++;
            if (pin == 1'b0 || tick_count >= lim) begin
               tick_count = 0;
               if (pending == MODE_WRITE_ALL) load_frame(frame_cmd(OP_MISC, ADDR_DISABLE), K_SWITCH);
               else seq = S_DONE;
            end
            return;
         end
         if (!timed_state(d)) return;
         tick_count++;
         // Zero-length waits fall straight through to the next state
         while (timed_state(d) && tick_count >= d) begin
            tick_count = 0;
            advance(pin);
         end
      endfunction

      function void start(logic [2:0] mode, logic [ADDRESS_BITS-1:0] addr,
                          logic [WORD_BITS-1:0] wdata, logic [COUNT_W-1:0] count, logic blk);
         int unsigned n;
         n = count;
         pending = mode;
         data_shift = '0;
         block_bit = blk;
         case (mode)
            MODE_READ: begin
               if (n == 0) n = 1;
               if (n > MAX_BURST) n = MAX_BURST;
               words_left = n;
               load_frame(frame_cmd(OP_READ, addr), K_READ);
            end
            MODE_WRITE: begin
               data_shift = wdata;
               load_frame(frame_cmd(OP_WRITE, addr), K_WRITE);
            end
            MODE_ENABLE:  load_frame(frame_cmd(OP_MISC, ADDR_ENABLE), K_SWITCH);
            MODE_DISABLE: load_frame(frame_cmd(OP_MISC, ADDR_DISABLE), K_SWITCH);
            default: begin
               data_shift = wdata;
               load_frame(frame_cmd(OP_MISC, ADDR_ENABLE), K_SWITCH);
            end
         endcase
      endfunction

      // Advance the sequence by one accepted item and queue the pins it should produce
      function void note_item(logic [2:0] mode, logic [ADDRESS_BITS-1:0] addr,
                              logic [WORD_BITS-1:0] wdata, logic [COUNT_W-1:0] count,
                              logic blk, logic pin);
         result_type want;
         bit was_busy;
         was_busy = in_frame();
         word_done = 1'b0;
         word_final = 1'b0;
         if (mode == MODE_TICK) tick(pin);
         else if (mode <= MODE_WRITE_ALL && !was_busy) start(mode, addr, wdata, count, blk);

         want.chip_select  = 1'b0;
         want.serial_clock = 1'b1;
         want.data_in_pin  = 1'b1;
         case (seq)
            S_LEAD: want.data_in_pin = 1'b0;
            S_SETUP: begin
               want.serial_clock = 1'b0;
               want.data_in_pin  = 1'b0;
            end
            S_CMD: begin
               want.chip_select  = 1'b1;
               want.serial_clock = (phase >= 2);
               want.data_in_pin  = cmd_shift[CMD_BITS - 1 - int'(bit_index)];
            end
            S_DOUT: begin
               want.chip_select  = 1'b1;
               want.serial_clock = (phase >= 2);
               want.data_in_pin  = data_shift[WORD_BITS - 1 - int'(bit_index)];
            end
            S_DUMMY, S_DIN: begin
               want.chip_select  = 1'b1;
               want.serial_clock = (phase >= 2);
               want.data_in_pin  = 1'b0;
            end
            S_TAIL: begin
               want.chip_select  = 1'b1;
               want.serial_clock = 1'b0;
               want.data_in_pin  = 1'b0;
            end
            S_SETTLE: want.data_in_pin = 1'b0;
            S_POLL: begin
               want.chip_select = 1'b1;
               want.data_in_pin = 1'b0;
            end
            default: ;
         endcase
         want.read_word  = last_word;
         want.read_valid = word_done;
         want.read_last  = word_final;
         want.status = (seq == S_IDLE) ? STATUS_IDLE :
                       (seq == S_DONE) ? STATUS_DONE : STATUS_BUSY;
         pending_pins.push_back(want);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("MISMATCH %s", what);
      endtask

      task check_pins(logic cs, logic sck, logic din, logic [WORD_BITS-1:0] word,
                      logic rv, logic rl, logic [1:0] st);
         result_type want;
         beats++;
         if (pending_pins.size() == 0) begin
            report_mismatch($sformatf("beat %0d: result with no item waiting", beats));
            return;
         end
         want = pending_pins.pop_front();
         if (cs !== want.chip_select)
            report_mismatch($sformatf("beat %0d: chip_select %b, want %b",
                                      beats, cs, want.chip_select));
         if (sck !== want.serial_clock)
            report_mismatch($sformatf("beat %0d: serial_clock %b, want %b",
                                      beats, sck, want.serial_clock));
         if (din !== want.data_in_pin)
            report_mismatch($sformatf("beat %0d: data_in_pin %b, want %b",
                                      beats, din, want.data_in_pin));
         if (word !== want.read_word)
            report_mismatch($sformatf("beat %0d: read_word %h, want %h",
                                      beats, word, want.read_word));
         if (rv !== want.read_valid)
            report_mismatch($sformatf("beat %0d: read_valid %b, want %b",
                                      beats, rv, want.read_valid));
         if (rl !== want.read_last)
            report_mismatch($sformatf("beat %0d: read_last %b, want %b",
                                      beats, rl, want.read_last));
         if (st !== want.status)
            report_mismatch($sformatf("beat %0d: status %0d, want %0d",
                                      beats, st, want.status));
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [2:0]              req_mode;
   logic [ADDRESS_BITS-1:0] req_address;
   logic [WORD_BITS-1:0]    req_write_data;
   logic [COUNT_W-1:0]      req_word_count;
   logic                    req_block_select;
   logic                    req_data_out_pin;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b1;
   logic                    rsp_chip_select;
   logic                    rsp_serial_clock;
   logic                    rsp_data_in_pin;
   logic [WORD_BITS-1:0]    rsp_read_word;
   logic                    rsp_read_valid;
   logic                    rsp_read_last;
   logic [1:0]              rsp_status;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   frame_tracker board;
   bit          gaps_on = 1'b1;
   int unsigned cycles = 0;
   int          stall_left = 0;

   microwire_eeprom_master u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .req_word_count   (req_word_count),
      .req_block_select (req_block_select),
      .req_data_out_pin (req_data_out_pin),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_chip_select  (rsp_chip_select),
      .rsp_serial_clock (rsp_serial_clock),
      .rsp_data_in_pin  (rsp_data_in_pin),
      .rsp_read_word    (rsp_read_word),
      .rsp_read_valid   (rsp_read_valid),
      .rsp_read_last    (rsp_read_last),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #2 clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Stall the result channel in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 15) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Check each result beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         board.check_pins(rsp_chip_select, rsp_serial_clock, rsp_data_in_pin, rsp_read_word,
                          rsp_read_valid, rsp_read_last, rsp_status);
   end

   function automatic logic pick_pin(int style);
      case (style)
         1:       return ($urandom_range(0, 15) != 0);
         2:       return ($urandom_range(0, 15) == 0);
         3:       return 1'b1;
         default: return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // Present one item, hold it until accepted, then advance the prediction
   task automatic send_item(logic [2:0] mode, logic [ADDRESS_BITS-1:0] addr,
                            logic [WORD_BITS-1:0] wdata, logic [COUNT_W-1:0] count,
                            logic blk, logic pin);
      if (gaps_on && $urandom_range(0, 11) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_address      <= addr;
      req_write_data   <= wdata;
      req_word_count   <= count;
      req_block_select <= blk;
      req_data_out_pin <= pin;
      do @(posedge clock); while (req_ready !== 1'b1);
      board.note_item(mode, addr, wdata, count, blk, pin);
      @(negedge clock);
   endtask

   task automatic send_tick(int style);
      send_item(MODE_TICK, ADDRESS_BITS'($urandom), WORD_BITS'($urandom), COUNT_W'($urandom),
                1'($urandom), pick_pin(style));
   endtask

   // Commands that the block must drop: anything mid-frame, or an unused mode
   task automatic send_noise();
      logic [2:0] mode;
      mode = board.in_frame() ? 3'($urandom_range(1, 7)) : 3'($urandom_range(6, 7));
      send_item(mode, ADDRESS_BITS'($urandom), WORD_BITS'($urandom), COUNT_W'($urandom),
                1'($urandom), 1'($urandom));
   endtask

   task automatic run_ticks(int n, int style);
      repeat (n) send_tick(style);
   endtask

   // Tick the sequence until it reaches the given state, with dropped commands mixed in
   task automatic tick_to(state_type target, int style);
      while (board.seq != target) begin
         if (board.in_frame() && $urandom_range(0, 39) == 0) send_noise();
         else send_tick(style);
      end
   endtask

   task automatic run_frame(logic [2:0] mode, logic [ADDRESS_BITS-1:0] addr,
                            logic [WORD_BITS-1:0] wdata, logic [COUNT_W-1:0] count,
                            logic blk, int style);
      send_item(mode, addr, wdata, count, blk, 1'($urandom));
      tick_to(S_DONE, style);
   endtask

   // Pause the sender until every expected beat has come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (board.pending_pins.size() != 0) @(negedge clock);
   endtask

   task automatic set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.write_reg(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(int unsigned p, int unsigned s, int unsigned t, int unsigned l);
      hold_until_drained();
      set_reg(CSR_PHASE, CSR_DATA_W'(p));
      set_reg(CSR_SETUP, CSR_DATA_W'(s));
      set_reg(CSR_SETTLE, CSR_DATA_W'(t));
      set_reg(CSR_POLL, CSR_DATA_W'(l));
   endtask

   initial begin
      board = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = MODE_TICK;
      req_address      = '0;
      req_write_data   = '0;
      req_word_count   = '0;
      req_block_select = 1'b0;
      req_data_out_pin = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = CSR_PHASE;
      csr_data         = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Idle block: a tick does nothing, unused modes are dropped
      send_tick(0);
      send_item(3'd6, 8'hFF, 16'hFFFF, 9'h1FF, 1'b1, 1'b1);
      send_item(3'd7, 8'h00, 16'h0000, 9'h000, 1'b0, 1'b0);

      // Reset timing, every command mid-frame dropped, then a phase write mid-frame
      send_item(MODE_DISABLE, 8'h00, 16'h0000, 9'd0, 1'b0, 1'b0);
      for (int m = 1; m <= 7; m++)
         send_item(3'(m), 8'h7E, 16'h8001, 9'd1, 1'b1, 1'b1);
      run_ticks(14, 0);
      hold_until_drained();
      set_reg(CSR_PHASE, CSR_DATA_W'(1));
      tick_to(S_DONE, 0);

      // Fast timing, skipped setup and settle waits, short poll
      configure(1, 0, 0, 5);
      run_frame(MODE_READ, 8'hAA, 16'hFFFF, 9'd2, 1'b1, 0);
      run_frame(MODE_WRITE_ALL, 8'hC3, 16'h1234, 9'd0, 1'b1, 3);

      // Zero phase and poll limit behave as one; no idling from here on
      gaps_on = 1'b0;
      configure(0, 2, 1, 0);
      run_frame(MODE_WRITE, 8'h3F, 16'h8001, 9'd1, 1'b0, 3);

      // Drain and let the pipeline empty out
      hold_until_drained();
      repeat (8) @(negedge clock);
      if (board.mismatches == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
